>>> rtl/core/slbd_pkg.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline: shared types and constants
// Character codes, front-to-back command encoding and channel widths.
// ----------------------------------------------------------------------------
package slbd_pkg;

   // Channel widths
   localparam int REQ_TDATA_W = 16;
   localparam int REQ_TUSER_W = 3;
   localparam int RSP_TDATA_W = 40;

   // Request function selector codes
   localparam logic [2:0] FUNC_LINE_RX    = 3'd0;
   localparam logic [2:0] FUNC_HOST_WRITE = 3'd1;
   localparam logic [2:0] FUNC_TX_DONE    = 3'd2;
   localparam logic [2:0] FUNC_HOST_READ  = 3'd3;
   localparam logic [2:0] FUNC_HOST_PEEK  = 3'd4;

   // Character codes
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_ESC   = 8'h1B;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DEL   = 8'h7F;
   localparam logic [7:0] CH_LBRK  = 8'h5B;
   localparam logic [7:0] CH_ONE   = 8'h31;
   localparam logic [7:0] CH_UP_D  = 8'h44;
   localparam logic [7:0] CH_UP_K  = 8'h4B;

   // Delete echo: ESC [ 1 D, start transmitter, ESC [ K
   localparam int         DEL_STEP_W     = 3;
   localparam logic [2:0] DEL_STEP_START = 3'd3;
   localparam logic [2:0] DEL_STEP_LAST  = 3'd6;

   // Classified command operations
   typedef logic [2:0] op_type;
   localparam op_type OP_NOP   = 3'd0;
   localparam op_type OP_LINE  = 3'd1;
   localparam op_type OP_WRITE = 3'd2;
   localparam op_type OP_DONE  = 3'd3;
   localparam op_type OP_READ  = 3'd4;
   localparam op_type OP_PEEK  = 3'd5;
   localparam op_type OP_DEL   = 3'd6;

   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      logic       echo;
      logic       kick;
   } cmd_type;

   // Command queue between front and back
   localparam int QUEUE_DEPTH = 2;

   function automatic logic [7:0] del_seq_byte(input logic [DEL_STEP_W-1:0] idx);
      logic [7:0] b;
      case (idx)
         3'd0:    b = CH_ESC;
         3'd1:    b = CH_LBRK;
         3'd2:    b = CH_ONE;
         3'd3:    b = CH_UP_D;
         3'd4:    b = CH_ESC;
         3'd5:    b = CH_LBRK;
         3'd6:    b = CH_UP_K;
         default: b = CH_ESC;
      endcase
      return b;
   endfunction

endpackage

>>> rtl/core/serial_line_buffer_discipline_core.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline core
// Receive and transmit byte rings with terminal line handling.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transaction per event; tuser selects line receive, host
//   write, tx done, host read or host peek, tdata carries the byte and kick.
//   rsp channel: exactly one transaction per request, in request order, with
//   the byte handed to the transmitter, the byte read, and ring status.
//   csr channel: writes the echo enable bit; always ready, write only while
//   no request is outstanding.
//   The front end classifies a request in its accept cycle and queues it
//   (two entries). The back-end sequencer pops it, makes each ring memory
//   access in its own state, takes read data from the registered RAM
//   output, and then loads the response register; it carries out one
//   request at a time and pops the next only after that response load.
//   Reset clears both rings, the newline count, the busy flag and the echo
//   bit; ring memories need no clearing. When the receiver stalls rsp, the
//   finished transaction is held, the sequencer waits at its end and the
//   queue keeps taking requests until it is full.
// ----------------------------------------------------------------------------
module serial_line_buffer_discipline_core import slbd_pkg::*; #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte, [8] kick, [15:9] zero
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [2:0] func
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] read_valid, [17:10] read_byte,
   // [18] line_ready, [26:19] rx_level, [34:27] tx_level, [35] tx_busy_flag,
   // [39:36] zero
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata
);

   logic    q_push, q_full, q_pop, q_valid;
   cmd_type q_in_cmd, q_out_cmd;

   slbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .q_push     (q_push),
      .q_cmd      (q_in_cmd),
      .q_full     (q_full)
   );

   slbd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_cmd  (q_in_cmd),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_cmd   (q_out_cmd)
   );

   slbd_back #(
      .RX_DEPTH (RX_DEPTH),
      .TX_DEPTH (TX_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_cmd      (q_out_cmd),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

>>> rtl/core/slbd_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module slbd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/slbd_front.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline: front end
// Holds the echo register, accepts request transactions and classifies them
// into ring commands for the back end.
// ----------------------------------------------------------------------------
module slbd_front import slbd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // request channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,   // [7:0] data_byte, [8] kick
   input  logic [REQ_TUSER_W-1:0] req_tuser,   // [2:0] func
   // register write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic                   csr_wdata,
   // command queue
   output logic                   q_push,
   output cmd_type                q_cmd,
   input  logic                   q_full
);

   logic       echo_enable_ff;
   logic       echo_enable_in;
   logic [7:0] data_byte;
   logic [7:0] rx_byte;
   logic       kick;

   assign csr_ready      = 1'b1;
   assign echo_enable_in = (csr_valid && csr_ready) ? csr_wdata : echo_enable_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         echo_enable_ff <= 1'b0;
      end else begin
         echo_enable_ff <= echo_enable_in;
      end
   end

   assign data_byte = req_tdata[7:0];
   assign kick      = req_tdata[8];
   // map CR to LF on the line side only
   assign rx_byte   = (data_byte == CH_CR) ? CH_LF : data_byte;

   always_comb begin
      q_cmd.op   = OP_NOP;
      q_cmd.data = data_byte;
      q_cmd.echo = 1'b0;
      q_cmd.kick = kick;
      unique case (req_tuser)
         FUNC_LINE_RX: begin
            q_cmd.data = rx_byte;
            if (rx_byte == CH_DEL) begin
               q_cmd.op = echo_enable_ff ? OP_DEL : OP_NOP;
            end else if (rx_byte == CH_LF || rx_byte >= CH_SPACE) begin
               q_cmd.op   = OP_LINE;
               // printable and LF echo, upper half is stored silently
               q_cmd.echo = echo_enable_ff && (rx_byte < CH_DEL);
            end
         end
         FUNC_HOST_WRITE: q_cmd.op = OP_WRITE;
         FUNC_TX_DONE:    q_cmd.op = OP_DONE;
         FUNC_HOST_READ:  q_cmd.op = OP_READ;
         FUNC_HOST_PEEK:  q_cmd.op = OP_PEEK;
         default:         q_cmd.op = OP_NOP;
      endcase
   end

   assign req_tready = !q_full;
   assign q_push     = req_tvalid && !q_full;

endmodule

>>> rtl/core/slbd_queue.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline: command queue
// Short FIFO of classified commands between front and back end.
// ----------------------------------------------------------------------------
module slbd_queue import slbd_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   output logic    full,
   input  logic    pop,
   output logic    pop_valid,
   output cmd_type pop_cmd
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entries_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

>>> rtl/core/slbd_back.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline: back end
// Sequencer that carries out one command at a time on the receive and
// transmit rings, one ring access per cycle, and holds the response register.
// ----------------------------------------------------------------------------
module slbd_back import slbd_pkg::*; #(
   parameter int RX_DEPTH = 256,
   parameter int TX_DEPTH = 256
) (
   input  logic                   clock,
   input  logic                   reset,
   // command queue
   input  logic                   q_valid,
   input  cmd_type                q_cmd,
   output logic                   q_pop,
   // response channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_LW = (RX_AW > 8) ? RX_AW : 8;
   localparam int TX_LW = (TX_AW > 8) ? TX_AW : 8;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_EXEC      = 4'd1;
   localparam logic [3:0] S_RX_EVICT  = 4'd2;
   localparam logic [3:0] S_ECHO      = 4'd3;
   localparam logic [3:0] S_TXCR      = 4'd4;
   localparam logic [3:0] S_START     = 4'd5;
   localparam logic [3:0] S_POP_WAIT  = 4'd6;
   localparam logic [3:0] S_RD_WAIT   = 4'd7;
   localparam logic [3:0] S_DEL_RD    = 4'd8;
   localparam logic [3:0] S_DEL_PUSH  = 4'd9;
   localparam logic [3:0] S_DEL_START = 4'd10;
   localparam logic [3:0] S_RESP      = 4'd11;

   function automatic logic [RX_AW-1:0] rx_next(input logic [RX_AW-1:0] p);
      return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + RX_AW'(1);
   endfunction

   function automatic logic [RX_AW-1:0] rx_prev(input logic [RX_AW-1:0] p);
      return (p == '0) ? RX_AW'(RX_DEPTH - 1) : p - RX_AW'(1);
   endfunction

   function automatic logic [TX_AW-1:0] tx_next(input logic [TX_AW-1:0] p);
      return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + TX_AW'(1);
   endfunction

   // control state
   logic [3:0]       state_ff, state_in;
   logic [RX_AW-1:0] rx_head_ff, rx_head_in;
   logic [RX_AW-1:0] rx_tail_ff, rx_tail_in;
   logic [RX_AW-1:0] rx_cnt_ff, rx_cnt_in;
   logic [RX_AW-1:0] nl_cnt_ff, nl_cnt_in;
   logic [TX_AW-1:0] tx_head_ff, tx_head_in;
   logic [TX_AW-1:0] tx_tail_ff, tx_tail_in;
   logic [TX_AW-1:0] tx_cnt_ff, tx_cnt_in;
   logic             tx_busy_ff, tx_busy_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // payload
   cmd_type                cmd_ff, cmd_in;
   logic [DEL_STEP_W-1:0]  step_ff, step_in;
   logic                   sent_ff, sent_in;
   logic [7:0]             sbyte_ff, sbyte_in;
   logic                   rvalid_ff, rvalid_in;
   logic [7:0]             rbyte_ff, rbyte_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // ring ports
   logic             rx_we, rx_re;
   logic [RX_AW-1:0] rx_wa, rx_ra;
   logic [7:0]       rx_rd;
   logic             tx_we, tx_re;
   logic [TX_AW-1:0] tx_ra;
   logic [7:0]       tx_wd, tx_rd;

   logic             tx_push, tx_pop;
   logic [7:0]       tx_push_byte;
   logic             rx_full, rx_empty, tx_full, tx_empty;
   logic             rsp_load;
   logic [RX_LW-1:0] rx_cnt_wide;
   logic [TX_LW-1:0] tx_cnt_wide;
   logic [7:0]       rx_level, tx_level;

   assign rx_full  = (rx_cnt_ff == RX_AW'(RX_DEPTH - 1));
   assign rx_empty = (rx_cnt_ff == '0);
   assign tx_full  = (tx_cnt_ff == TX_AW'(TX_DEPTH - 1));
   assign tx_empty = (tx_cnt_ff == '0);

   always_comb begin
      state_in     = state_ff;
      rx_head_in   = rx_head_ff;
      rx_tail_in   = rx_tail_ff;
      rx_cnt_in    = rx_cnt_ff;
      nl_cnt_in    = nl_cnt_ff;
      tx_head_in   = tx_head_ff;
      tx_tail_in   = tx_tail_ff;
      tx_cnt_in    = tx_cnt_ff;
      tx_busy_in   = tx_busy_ff;
      cmd_in       = cmd_ff;
      step_in      = step_ff;
      sent_in      = sent_ff;
      sbyte_in     = sbyte_ff;
      rvalid_in    = rvalid_ff;
      rbyte_in     = rbyte_ff;
      q_pop        = 1'b0;
      rsp_load     = 1'b0;
      rx_we        = 1'b0;
      rx_wa        = rx_head_ff;
      rx_re        = 1'b0;
      rx_ra        = rx_tail_ff;
      tx_push      = 1'b0;
      tx_push_byte = cmd_ff.data;
      tx_pop       = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop     = 1'b1;
               cmd_in    = q_cmd;
               sent_in   = 1'b0;
               sbyte_in  = '0;
               rvalid_in = 1'b0;
               rbyte_in  = '0;
               state_in  = S_EXEC;
            end
         end
         S_EXEC: begin
            case (cmd_ff.op) inside
               OP_LINE: begin
                  if (rx_full) begin
                     // fetch the oldest byte to learn whether an LF is evicted
                     rx_re    = 1'b1;
                     state_in = S_RX_EVICT;
                  end else begin
                     rx_we      = 1'b1;
                     rx_head_in = rx_next(rx_head_ff);
                     rx_cnt_in  = rx_cnt_ff + RX_AW'(1);
                     nl_cnt_in  = nl_cnt_ff + RX_AW'(cmd_ff.data == CH_LF);
                     state_in   = cmd_ff.echo ? S_ECHO : S_RESP;
                  end
               end
               OP_DEL: begin
                  if (rx_empty) begin
                     state_in = S_RESP;
                  end else begin
                     rx_head_in = rx_prev(rx_head_ff);
                     rx_cnt_in  = rx_cnt_ff - RX_AW'(1);
                     rx_re      = 1'b1;
                     rx_ra      = rx_prev(rx_head_ff);
                     state_in   = S_DEL_RD;
                  end
               end
               OP_WRITE: begin
                  tx_push = 1'b1;
                  if (cmd_ff.data == CH_LF) begin
                     state_in = S_TXCR;
                  end else begin
                     state_in = cmd_ff.kick ? S_START : S_RESP;
                  end
               end
               OP_DONE: begin
                  if (tx_empty) begin
                     tx_busy_in = 1'b0;
                     state_in   = S_RESP;
                  end else begin
                     tx_pop   = 1'b1;
                     state_in = S_POP_WAIT;
                  end
               end
               OP_READ, OP_PEEK: begin
                  if (rx_empty) begin
                     state_in = S_RESP;
                  end else begin
                     rx_re    = 1'b1;
                     state_in = S_RD_WAIT;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_RX_EVICT: begin
            rx_we      = 1'b1;
            rx_head_in = rx_next(rx_head_ff);
            rx_tail_in = rx_next(rx_tail_ff);
            nl_cnt_in  = nl_cnt_ff + RX_AW'(cmd_ff.data == CH_LF) - RX_AW'(rx_rd == CH_LF);
            state_in   = cmd_ff.echo ? S_ECHO : S_RESP;
         end
         S_ECHO: begin
            tx_push  = 1'b1;
            state_in = (cmd_ff.data == CH_LF) ? S_TXCR : S_RESP;
         end
         S_TXCR: begin
            tx_push      = 1'b1;
            tx_push_byte = CH_CR;
            state_in     = (cmd_ff.op == OP_WRITE && cmd_ff.kick) ? S_START : S_RESP;
         end
         S_START: begin
            if (!tx_busy_ff && !tx_empty) begin
               tx_pop     = 1'b1;
               tx_busy_in = 1'b1;
               state_in   = S_POP_WAIT;
            end else begin
               state_in = S_RESP;
            end
         end
         S_POP_WAIT: begin
            sent_in  = 1'b1;
            sbyte_in = tx_rd;
            state_in = (cmd_ff.op == OP_DEL) ? S_DEL_PUSH : S_RESP;
         end
         S_RD_WAIT: begin
            rvalid_in = 1'b1;
            rbyte_in  = rx_rd;
            if (cmd_ff.op == OP_READ) begin
               rx_tail_in = rx_next(rx_tail_ff);
               rx_cnt_in  = rx_cnt_ff - RX_AW'(1);
               nl_cnt_in  = nl_cnt_ff - RX_AW'(rx_rd == CH_LF);
            end
            state_in = S_RESP;
         end
         S_DEL_RD: begin
            nl_cnt_in = nl_cnt_ff - RX_AW'(rx_rd == CH_LF);
            step_in   = '0;
            state_in  = S_DEL_PUSH;
         end
         S_DEL_PUSH: begin
            tx_push      = 1'b1;
            tx_push_byte = del_seq_byte(step_ff);
            step_in      = step_ff + DEL_STEP_W'(1);
            if (step_ff == DEL_STEP_START) begin
               state_in = S_DEL_START;
            end else if (step_ff == DEL_STEP_LAST) begin
               // the start after ESC [ K finds the transmitter busy already
               state_in = S_RESP;
            end
         end
         S_DEL_START: begin
            if (!tx_busy_ff && !tx_empty) begin
               tx_pop     = 1'b1;
               tx_busy_in = 1'b1;
               state_in   = S_POP_WAIT;
            end else begin
               state_in = S_DEL_PUSH;
            end
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase

      // transmit ring bookkeeping; push and pop never share a cycle
      if (tx_push) begin
         tx_head_in = tx_next(tx_head_ff);
         if (tx_full) begin
            tx_tail_in = tx_next(tx_tail_ff);
         end else begin
            tx_cnt_in = tx_cnt_ff + TX_AW'(1);
         end
      end
      if (tx_pop) begin
         tx_tail_in = tx_next(tx_tail_ff);
         tx_cnt_in  = tx_cnt_ff - TX_AW'(1);
      end
   end

   assign tx_we = tx_push;
   assign tx_wd = tx_push_byte;
   assign tx_re = tx_pop;
   assign tx_ra = tx_tail_ff;

   // saturate levels to the 8-bit report fields
   assign rx_cnt_wide = RX_LW'(rx_cnt_ff);
   assign tx_cnt_wide = TX_LW'(tx_cnt_ff);
   assign rx_level    = (rx_cnt_wide > RX_LW'(255)) ? 8'hFF : rx_cnt_wide[7:0];
   assign tx_level    = (tx_cnt_wide > TX_LW'(255)) ? 8'hFF : tx_cnt_wide[7:0];

   assign rsp_data_in = rsp_load ?
      {4'b0000, tx_busy_ff, tx_level, rx_level, (nl_cnt_ff != '0),
       rbyte_ff, rvalid_ff, sbyte_ff, sent_ff} : rsp_data_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rx_head_ff   <= '0;
         rx_tail_ff   <= '0;
         rx_cnt_ff    <= '0;
         nl_cnt_ff    <= '0;
         tx_head_ff   <= '0;
         tx_tail_ff   <= '0;
         tx_cnt_ff    <= '0;
         tx_busy_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rx_head_ff   <= rx_head_in;
         rx_tail_ff   <= rx_tail_in;
         rx_cnt_ff    <= rx_cnt_in;
         nl_cnt_ff    <= nl_cnt_in;
         tx_head_ff   <= tx_head_in;
         tx_tail_ff   <= tx_tail_in;
         tx_cnt_ff    <= tx_cnt_in;
         tx_busy_ff   <= tx_busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      step_ff     <= step_in;
      sent_ff     <= sent_in;
      sbyte_ff    <= sbyte_in;
      rvalid_ff   <= rvalid_in;
      rbyte_ff    <= rbyte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   slbd_ram #(
      .WIDTH (8),
      .DEPTH (RX_DEPTH)
   ) u_rx_ram (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_wa),
      .wr_data (cmd_ff.data),
      .rd_en   (rx_re),
      .rd_addr (rx_ra),
      .rd_data (rx_rd)
   );

   slbd_ram #(
      .WIDTH (8),
      .DEPTH (TX_DEPTH)
   ) u_tx_ram (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_head_ff),
      .wr_data (tx_wd),
      .rd_en   (tx_re),
      .rd_addr (tx_ra),
      .rd_data (tx_rd)
   );

endmodule

>>> rtl/core/slbd_checker.sv
// ----------------------------------------------------------------------------
// Serial line buffer discipline: port checker
// Concurrent checks on the top-level ports, bound to the core.
// ----------------------------------------------------------------------------
module slbd_port_checker import slbd_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled response transaction holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp payload changed while stalled");

   // no response is left over from before reset
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp valid right after reset");

   // tx_byte is zero unless a byte was handed over
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'h00)
      else $error("tx_byte set without tx_valid");

   // read_byte is zero unless read or peek found a byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[9] |-> rsp_tdata[17:10] == 8'h00)
      else $error("read_byte set without read_valid");

   // a held line implies a non-empty receive ring
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[18] |-> rsp_tdata[26:19] != 8'h00)
      else $error("line_ready with empty receive ring");

endmodule

bind serial_line_buffer_discipline_core slbd_port_checker u_slbd_port_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
